@@ rtl/mrrs_pkg.sv @@
// shared constants, types and operation codes for the round-robin scheduler
`timescale 1ns / 1ps
package mrrs_pkg;
   localparam int CpuCountDefault   = 4;
   localparam int QueueDepthDefault = 32;
   localparam int TaskWidth         = 8;
   localparam int QuantumWidth      = 16;
   localparam int CsrDataWidth      = 16;
   localparam int CsrIndexWidth     = 3;

   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_UNBLOCK = 3'd1;
   localparam logic [2:0] OP_TICK    = 3'd2;
   localparam logic [2:0] OP_BLOCK   = 3'd3;
   localparam logic [2:0] OP_EXIT    = 3'd4;

   localparam logic [CsrIndexWidth-1:0] REG_CPUS     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_QUANTUM0 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_QUANTUM1 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_QUANTUM2 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_QUANTUM3 = 3'd4;

   // one queue entry
   typedef struct packed {
      logic [TaskWidth-1:0] task_id;
      logic                 blocked;
   } entry_type;

   // command from the sequencer to the row of queue cells
   typedef struct packed {
      logic                 shift;
      logic                 push;
      entry_type            push_entry;
      logic                 unblock;
      logic [TaskWidth-1:0] unblock_id;
   } qcmd_type;
endpackage

@@ rtl/multicore_round_robin_scheduler.sv @@
// top level: per-cpu state, command sequencer and result register
//  channel  dir  signals                       payload
//  req      in   req_tvalid/tready/tdata       operation, cpu, task_id
//  rsp      out  rsp_tvalid/tready/tdata       next_task, idle, decided, queue_full
//  csr      in   csr_we/csr_index/csr_wdata    register write
// load, unblock and ticks without expiry go straight to the result slot
// a pick rotates through the cell row one entry a cycle
// one item at a time; req_tready is low while busy or while a result waits
// reset is synchronous and empties the queue and idles every cpu
`timescale 1ns / 1ps
module multicore_round_robin_scheduler #(
   parameter int CPU_COUNT   = mrrs_pkg::CpuCountDefault,
   parameter int QUEUE_DEPTH = mrrs_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // operation[2:0], cpu[4:3], task_id[12:5]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // next_task[7:0], idle, decided, queue_full
   input  logic        csr_we,
   input  logic [mrrs_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [mrrs_pkg::CsrDataWidth-1:0]  csr_wdata
);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int CPW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam logic [1:0] S_IDLE = 2'd0, S_PICK = 2'd1, S_OUT = 2'd2;

   logic [2:0] cpus_ff;
   logic [mrrs_pkg::QuantumWidth-1:0] quantum_ff [4];
   logic [mrrs_pkg::TaskWidth-1:0] run_task_ff [CPU_COUNT];
   logic [CPU_COUNT-1:0] run_valid_ff;
   logic [mrrs_pkg::QuantumWidth-1:0] slice_ff [CPU_COUNT];
   logic [CW-1:0] count_ff, count_in, left_ff, left_in;
   logic [1:0] state_ff, state_in;
   logic [CPW-1:0] cpu_ff, cpu_in;
   logic full_ff, full_in;
   logic [15:0] rsp_ff, rsp_in;

   mrrs_pkg::qcmd_type cmd;
   mrrs_pkg::entry_type head;

   logic [2:0] op;
   logic [1:0] rcpu;
   logic [mrrs_pkg::TaskWidth-1:0] rid;
   logic [2:0] ncpu;
   logic cpu_ok, fire, qfull;
   logic [CPW-1:0] ci;

   assign op   = req_tdata[2:0];
   assign rcpu = req_tdata[4:3];
   assign rid  = req_tdata[12:5];
   assign ncpu = (cpus_ff == 3'd0) ? 3'd1 :
                 (cpus_ff > 3'(CPU_COUNT)) ? 3'(CPU_COUNT) : cpus_ff;
   assign cpu_ok = {1'b0, rcpu} < ncpu;
   assign ci = CPW'(rcpu);
   assign req_tready = (state_ff == S_IDLE);
   assign fire = req_tvalid && req_tready;
   assign qfull = count_ff == CW'(QUEUE_DEPTH);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = rsp_ff;

   mrrs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .cmd(cmd), .count(count_ff), .head(head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cpus_ff <= 3'd4;
         for (int k = 0; k < 4; k++) quantum_ff[k] <= 16'd10;
      end else if (csr_we) begin
         if (csr_index == mrrs_pkg::REG_CPUS) begin
            cpus_ff <= csr_wdata[2:0];
         end else if (csr_index <= mrrs_pkg::REG_QUANTUM3) begin
            quantum_ff[2'(csr_index - mrrs_pkg::REG_QUANTUM0)] <= csr_wdata;
         end
      end
   end

   always_comb begin
      cmd = '0;
      cmd.unblock_id = rid;
      count_in = count_ff;
      left_in = left_ff;
      state_in = state_ff;
      cpu_in = cpu_ff;
      full_in = full_ff;
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               state_in = S_OUT;
               rsp_in = '0;
               full_in = 1'b0;
               cpu_in = ci;
               if (op == mrrs_pkg::OP_LOAD) begin
                  if (qfull) begin
                     rsp_in[10] = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                     cmd.push_entry = '{task_id: rid, blocked: 1'b0};
                     count_in = count_ff + 1'b1;
                  end
               end else if (op == mrrs_pkg::OP_UNBLOCK) begin
                  cmd.unblock = 1'b1;
               end else if (op <= mrrs_pkg::OP_EXIT && cpu_ok) begin
                  if (op == mrrs_pkg::OP_TICK && run_valid_ff[ci] && slice_ff[ci] > 16'd1) begin
                     rsp_in = {6'd0, 1'b1, 1'b0, run_task_ff[ci]};
                  end else if (op == mrrs_pkg::OP_TICK && count_ff == '0) begin
                     rsp_in = {6'd0, 1'b1, !run_valid_ff[ci],
                               run_valid_ff[ci] ? run_task_ff[ci] : 8'd0};
                  end else begin
                     state_in = S_PICK;
                     if (op != mrrs_pkg::OP_EXIT && run_valid_ff[ci]) begin
                        if (qfull) begin
                           full_in = 1'b1;
                        end else begin
                           cmd.push = 1'b1;
                           cmd.push_entry = '{task_id: run_task_ff[ci],
                                              blocked: op == mrrs_pkg::OP_BLOCK};
                           count_in = count_ff + 1'b1;
                        end
                     end
                     // the search covers the requeued task as well
                     left_in = count_in;
                  end
               end
            end
         end
         S_PICK: begin
            if (left_ff == '0) begin
               state_in = S_OUT;
               rsp_in = {5'd0, full_ff, 1'b1, 1'b1, 8'd0};
            end else if (!head.blocked) begin
               cmd.shift = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = S_OUT;
               rsp_in = {5'd0, full_ff, 1'b1, 1'b0, head.task_id};
            end else begin
               // rotate blocked head to tail
               cmd.shift = 1'b1;
               cmd.push = 1'b1;
               cmd.push_entry = head;
               left_in = left_ff - 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         run_valid_ff <= '0;
         for (int k = 0; k < CPU_COUNT; k++) begin
            run_task_ff[k] <= '0;
            slice_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == S_IDLE && fire && op >= mrrs_pkg::OP_TICK &&
             op <= mrrs_pkg::OP_EXIT && cpu_ok) begin
            if (op == mrrs_pkg::OP_TICK && run_valid_ff[ci] && slice_ff[ci] > 16'd1) begin
               slice_ff[ci] <= slice_ff[ci] - 1'b1;
            end else if (op == mrrs_pkg::OP_TICK && count_ff == '0) begin
               if (run_valid_ff[ci]) slice_ff[ci] <= quantum_ff[2'(ci)];
            end else begin
               run_valid_ff[ci] <= 1'b0;
            end
         end
         if (state_ff == S_PICK && left_ff != '0 && !head.blocked) begin
            run_valid_ff[cpu_ff] <= 1'b1;
            run_task_ff[cpu_ff] <= head.task_id;
            slice_ff[cpu_ff] <= quantum_ff[2'(cpu_ff)];
         end
      end
      left_ff <= left_in;
      cpu_ff <= cpu_in;
      full_ff <= full_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   a_pick_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK) |-> left_ff <= count_ff) else $error("pick overrun");
`endif
endmodule

@@ rtl/mrrs_cell.sv @@
// one queue slot; shifts toward the head and takes the tail push
`timescale 1ns / 1ps
module mrrs_cell (
   input  logic                clock,
   input  logic                reset,
   input  mrrs_pkg::qcmd_type  cmd,
   input  logic                is_tail,
   input  logic                next_tail,
   input  logic                occupied,
   input  mrrs_pkg::entry_type from_next,
   input  logic                match_before,
   output mrrs_pkg::entry_type entry,
   output logic                match_here
);
   mrrs_pkg::entry_type entry_ff, entry_in;

   assign entry = entry_ff;
   assign match_here = occupied && (entry_ff.task_id == cmd.unblock_id);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.unblock && match_here && !match_before) begin
         entry_in.blocked = 1'b0;
      end
      if (cmd.shift) begin
         entry_in = cmd.push && next_tail ? cmd.push_entry : from_next;
      end else if (cmd.push && is_tail) begin
         entry_in = cmd.push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.blocked <= 1'b0;
      end else begin
         entry_ff.blocked <= entry_in.blocked;
      end
      entry_ff.task_id <= entry_in.task_id;
   end
endmodule

@@ rtl/mrrs_queue.sv @@
// wait queue as a row of cells; head always in cell zero
`timescale 1ns / 1ps
module mrrs_queue #(
   parameter int QUEUE_DEPTH = mrrs_pkg::QueueDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mrrs_pkg::qcmd_type            cmd,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
   output mrrs_pkg::entry_type           head
);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   mrrs_pkg::entry_type ent [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] chain;

   assign chain[0] = 1'b0;
   assign head = ent[0];

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic occ, mh;
      mrrs_pkg::entry_type nxt;
      assign occ = CW'(g) < count;
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign nxt = ent[g];
      end else begin : g_mid
         assign nxt = ent[g + 1];
      end
      mrrs_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .is_tail(count == CW'(g)), .next_tail(count == CW'(g + 1)),
         .occupied(occ), .from_next(nxt), .match_before(chain[g]),
         .entry(ent[g]), .match_here(mh)
      );
      assign chain[g + 1] = chain[g] | mh;
   end
endmodule
